// ----- design/bdiou_pkg.sv -----
// ----------------------------------------------------------------------------
// bdiou_pkg
// Shared types and fixed widths for the box distance-IoU block.
// ----------------------------------------------------------------------------
package bdiou_pkg;

  // Fixed field widths
  localparam int unsigned CW    = 16;      // center coordinate
  localparam int unsigned SW    = 15;      // box size
  localparam int unsigned OUT_W = 16;      // result value
  localparam int unsigned XW    = CW + 2;  // doubled edges, extents, |dx|
  localparam int unsigned AW    = 2 * SW + 2;  // doubled-size area
  localparam int unsigned NW    = 2 * XW + 1;  // areas, union, squared sums

  // Input word
  typedef struct packed {
    logic signed [CW-1:0] a_center_x;
    logic signed [CW-1:0] a_center_y;
    logic        [SW-1:0] a_width;
    logic        [SW-1:0] a_height;
    logic signed [CW-1:0] b_center_x;
    logic signed [CW-1:0] b_center_y;
    logic        [SW-1:0] b_width;
    logic        [SW-1:0] b_height;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [OUT_W-1:0] diou_value;
    logic                    overlap_seen;
  } out_t;

  // Classified pair handed from the front to the back
  typedef struct packed {
    logic          overlap;
    logic [XW-1:0] iw;
    logic [XW-1:0] ih;
    logic [SW:0]   aw2;
    logic [SW:0]   ah2;
    logic [SW:0]   bw2;
    logic [SW:0]   bh2;
    logic [XW-1:0] adx;
    logic [XW-1:0] ady;
    logic [XW-1:0] ew;
    logic [XW-1:0] eh;
  } fr_t;

endpackage

// ----- design/bdiou_front.sv -----
// ----------------------------------------------------------------------------
// bdiou_front
// Builds doubled edges, intersection and enclosing extents, center deltas
// and the overlap class of one box pair.
// ----------------------------------------------------------------------------
module bdiou_front
  import bdiou_pkg::*;
(
  input  in_t in_i,
  output fr_t fr_o
);

  function automatic logic signed [XW-1:0] dbl(logic signed [CW-1:0] c);
    logic signed [XW-1:0] e;
    e = XW'(c);
    return e <<< 1;
  endfunction

  function automatic logic signed [XW-1:0] szx(logic [SW-1:0] s);
    return $signed({{(XW-SW){1'b0}}, s});
  endfunction

  function automatic logic signed [XW-1:0] smax(logic signed [XW-1:0] a,
                                                logic signed [XW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [XW-1:0] smin(logic signed [XW-1:0] a,
                                                logic signed [XW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Extent as unsigned, taken from a one-bit-wider signed difference
  function automatic logic [XW-1:0] span(logic signed [XW-1:0] hi,
                                         logic signed [XW-1:0] lo);
    logic signed [XW:0] d;
    d = (XW+1)'(hi) - (XW+1)'(lo);
    return d[XW-1:0];
  endfunction

  logic signed [XW-1:0] ax2, ay2, bx2, by2;
  logic signed [XW-1:0] al, ar, at, ab, bl, br, bt, bb;
  logic signed [XW-1:0] il, ir, it, ib;
  logic signed [XW-1:0] dx, dy;

  // Doubled edges
  assign ax2 = dbl(in_i.a_center_x);
  assign ay2 = dbl(in_i.a_center_y);
  assign bx2 = dbl(in_i.b_center_x);
  assign by2 = dbl(in_i.b_center_y);
  assign al  = ax2 - szx(in_i.a_width);
  assign ar  = ax2 + szx(in_i.a_width);
  assign at  = ay2 - szx(in_i.a_height);
  assign ab  = ay2 + szx(in_i.a_height);
  assign bl  = bx2 - szx(in_i.b_width);
  assign br  = bx2 + szx(in_i.b_width);
  assign bt  = by2 - szx(in_i.b_height);
  assign bb  = by2 + szx(in_i.b_height);

  // Intersection box
  assign il = smax(al, bl);
  assign ir = smin(ar, br);
  assign it = smax(at, bt);
  assign ib = smin(ab, bb);

  // Center deltas, doubled
  assign dx = ax2 - bx2;
  assign dy = ay2 - by2;

  always_comb begin
    fr_o.overlap = (ib >= it) && (ir >= il);
    fr_o.iw      = span(ir, il);
    fr_o.ih      = span(ib, it);
    fr_o.aw2     = {in_i.a_width, 1'b0};
    fr_o.ah2     = {in_i.a_height, 1'b0};
    fr_o.bw2     = {in_i.b_width, 1'b0};
    fr_o.bh2     = {in_i.b_height, 1'b0};
    fr_o.adx     = dx[XW-1] ? XW'(-dx) : XW'(dx);
    fr_o.ady     = dy[XW-1] ? XW'(-dy) : XW'(dy);
    fr_o.ew      = span(smax(ar, br), smin(al, bl));
    fr_o.eh      = span(smax(ab, bb), smin(at, bt));
  end

endmodule

// ----- design/bdiou_queue.sv -----
// ----------------------------------------------------------------------------
// bdiou_queue
// Small synchronous FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bdiou_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNW-1:0]  cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- design/bdiou_back.sv -----
// ----------------------------------------------------------------------------
// bdiou_back
// Products, sums and two pipelined restoring dividers, one quotient bit per
// stage, then the final subtract into the output register.
// ----------------------------------------------------------------------------
module bdiou_back
  import bdiou_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  fr_t  in_fr_i,
  output logic take_o,
  output logic out_valid_o,
  output out_t out_o,
  input  logic out_pop_i
);

  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam int unsigned RW = (QW > OUT_W) ? QW : OUT_W;

  typedef struct packed {
    logic          ok;
    logic [2*XW-1:0] inter;
    logic [AW-1:0] area_a;
    logic [AW-1:0] area_b;
    logic [2*XW-1:0] dx2;
    logic [2*XW-1:0] dy2;
    logic [2*XW-1:0] ew2;
    logic [2*XW-1:0] eh2;
  } prod_t;

  typedef struct packed {
    logic          ok;
    logic [NW-1:0] inter;
    logic [NW-1:0] uni;
    logic [NW-1:0] dsq;
    logic [NW-1:0] diag;
  } sum_t;

  typedef struct packed {
    logic          ok;
    logic          dz;
    logic [NW:0]   ri;
    logic [NW:0]   rd;
    logic [NW-1:0] di;
    logic [NW-1:0] dd;
    logic [QW-1:0] qi;
    logic [QW-1:0] qd;
  } div_t;

  logic          en;
  logic          s1_v_q, s2_v_q, out_v_q;
  logic [QW-1:0] dv_q;
  prod_t         s1_q;
  sum_t          s2_q;
  div_t          dstg_q [QW];
  div_t          d_init;
  out_t          out_q, out_d;
  logic [QW-1:0] qd_fin;
  logic [RW-1:0] diff;

  // Whole pipeline advances unless the result register is held
  assign en          = !out_v_q || out_pop_i;
  assign take_o      = en && in_valid_i;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      dv_q    <= {dv_q[QW-2:0], s2_v_q};
      out_v_q <= dv_q[QW-1];
    end
  end

  // Stage 1: products
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.ok     <= in_fr_i.overlap;
      s1_q.inter  <= in_fr_i.iw * in_fr_i.ih;
      s1_q.area_a <= in_fr_i.aw2 * in_fr_i.ah2;
      s1_q.area_b <= in_fr_i.bw2 * in_fr_i.bh2;
      s1_q.dx2    <= in_fr_i.adx * in_fr_i.adx;
      s1_q.dy2    <= in_fr_i.ady * in_fr_i.ady;
      s1_q.ew2    <= in_fr_i.ew * in_fr_i.ew;
      s1_q.eh2    <= in_fr_i.eh * in_fr_i.eh;
    end
  end

  // Stage 2: union and squared sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.ok    <= s1_q.ok;
      s2_q.inter <= NW'(s1_q.inter);
      s2_q.uni   <= NW'(s1_q.area_a) + NW'(s1_q.area_b) - NW'(s1_q.inter);
      s2_q.dsq   <= NW'(s1_q.dx2) + NW'(s1_q.dy2);
      s2_q.diag  <= NW'(s1_q.ew2) + NW'(s1_q.eh2);
    end
  end

  // Divider entry: flags for empty union and zero diagonal
  always_comb begin
    d_init.ok = s2_q.ok && (s2_q.uni != '0);
    d_init.dz = (s2_q.diag == '0);
    d_init.ri = {1'b0, s2_q.inter};
    d_init.rd = {1'b0, s2_q.dsq};
    d_init.di = s2_q.uni;
    d_init.dd = s2_q.diag;
    d_init.qi = '0;
    d_init.qd = '0;
  end

  // Divider stages: compare, subtract, shift
  for (genvar k = 0; k < QW; k++) begin : g_div
    div_t p;
    div_t nx;
    logic gi, gd;
    logic [NW:0] ni, nd;
    if (k == 0) begin : g_first
      assign p = d_init;
    end else begin : g_next
      assign p = dstg_q[k-1];
    end
    assign gi = (p.ri >= {1'b0, p.di});
    assign gd = (p.rd >= {1'b0, p.dd});
    assign ni = gi ? p.ri - {1'b0, p.di} : p.ri;
    assign nd = gd ? p.rd - {1'b0, p.dd} : p.rd;
    always_comb begin
      nx    = p;
      nx.ri = ni << 1;
      nx.rd = nd << 1;
      nx.qi = {p.qi[QW-2:0], gi};
      nx.qd = {p.qd[QW-2:0], gd};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dstg_q[k] <= nx;
      end
    end
  end

  // Final subtract, wrapped to the output width
  assign qd_fin = dstg_q[QW-1].dz ? '0 : dstg_q[QW-1].qd;
  assign diff   = RW'(dstg_q[QW-1].qi) - RW'(qd_fin);

  always_comb begin
    out_d.overlap_seen = dstg_q[QW-1].ok;
    out_d.diou_value   = dstg_q[QW-1].ok ? $signed(diff[OUT_W-1:0]) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- design/box_distance_iou.sv -----
// Throughput: one word per cycle while no unpopped result holds the pipeline;
// the quotient bits come from FRACTION_BITS + 1 pipelined divider stages, each
// resolving one bit for both quotients.
// A four-entry queue after the front lets input and result sides stall apart.
// Reset (asynchronous, active low) empties the queue and clears all valid bits.
// ----------------------------------------------------------------------------
// box_distance_iou
// Distance IoU of two center/size boxes, Q1.FRACTION_BITS result.
// ----------------------------------------------------------------------------
module box_distance_iou
  import bdiou_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_data_i,
  output logic empty,
  input  logic pop,
  output out_t out_data_o
);

  fr_t  fr_in, fr_out;
  logic q_empty, take, out_valid;

  // Classify the pair
  bdiou_front u_front (
    .in_i (in_data_i),
    .fr_o (fr_in)
  );

  // Decoupling queue
  bdiou_queue #(
    .T     (fr_t),
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_in),
    .full_o  (full),
    .pop_i   (take),
    .data_o  (fr_out),
    .empty_o (q_empty)
  );

  // Arithmetic pipeline
  bdiou_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_fr_i     (fr_out),
    .take_o      (take),
    .out_valid_o (out_valid),
    .out_o       (out_data_o),
    .out_pop_i   (pop)
  );

  assign empty = !out_valid;

endmodule

// ----- design/bdiou_checker.sv -----
// ----------------------------------------------------------------------------
// bdiou_checker
// Port-level checks for box_distance_iou, bound to the top level.
// ----------------------------------------------------------------------------
module bdiou_checker
  import bdiou_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t out_data_o
);

  // A waiting result word holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result word changed while stalled");

  // No overlap means a zero value
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.overlap_seen) |-> (out_data_o.diou_value == '0))
    else $error("nonzero value without overlap");

  // The queue only fills after a push
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // Results only drain after a pop
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result vanished without a pop");

endmodule

bind box_distance_iou bdiou_checker u_bdiou_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the box distance-IoU block word by word. A table of directed box
// pairs runs first, then about a thousand random pairs, most of them built
// to overlap. Each accepted pair is scored by a behavioral scorer in this
// file or by its table row's typed result; block results are compared in
// order. Input is driven in bursts; result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import bdiou_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC      = 14;
  localparam int unsigned LATENCY   = FRAC + 4;
  localparam int unsigned N_RANDOM  = 1000;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned WD_LIMIT  = 4000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  logic full;
  logic empty;
  in_t  in_data_i = '0;
  out_t out_data_o;

  // Expected results, oldest first
  out_t diou_expected[$];
  int   n_errors  = 0;
  int   idle_cyc  = 0;
  bit   hold_req  = 1'b0;
  bit   stim_done = 1'b0;

  // Typed expectation for the word now offered, if any
  bit   typed_valid = 1'b0;
  out_t typed_word;

  // Directed rows
  typedef struct {
    in_t  pair;
    bit   typed;
    out_t want;
  } row_t;
  row_t rows[$];

  always #4 clk_i = ~clk_i;

  box_distance_iou #(.FRACTION_BITS(FRAC)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  // DIoU of one box pair, on doubled edges
  function automatic out_t score_pair(in_t p);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint al, ar, at, ab, bl, br, bt, bb;
    longint il, ir, it, ib, inter, uni, dx, dy, dsq, ew, eh, diag;
    longint iou_q, dist_q;
    out_t   r;
    ax = longint'(p.a_center_x); ay = longint'(p.a_center_y);
    bx = longint'(p.b_center_x); by = longint'(p.b_center_y);
    aw = longint'({1'b0, p.a_width});  ah = longint'({1'b0, p.a_height});
    bw = longint'({1'b0, p.b_width});  bh = longint'({1'b0, p.b_height});
    al = 2 * ax - aw; ar = 2 * ax + aw; at = 2 * ay - ah; ab = 2 * ay + ah;
    bl = 2 * bx - bw; br = 2 * bx + bw; bt = 2 * by - bh; bb = 2 * by + bh;
    il = (al > bl) ? al : bl;
    ir = (ar < br) ? ar : br;
    it = (at > bt) ? at : bt;
    ib = (ab < bb) ? ab : bb;
    r = '0;
    if (ib < it || ir < il) return r;
    inter = (ir - il) * (ib - it);
    uni = (2 * aw) * (2 * ah) + (2 * bw) * (2 * bh) - inter;
    if (uni == 0) return r;
    dx = 2 * (ax - bx);
    dy = 2 * (ay - by);
    dsq = dx * dx + dy * dy;
    ew = ((ar > br) ? ar : br) - ((al < bl) ? al : bl);
    eh = ((ab > bb) ? ab : bb) - ((at < bt) ? at : bt);
    diag = ew * ew + eh * eh;
    iou_q = (inter <<< FRAC) / uni;
    dist_q = (diag != 0) ? (dsq <<< FRAC) / diag : 0;
    r.diou_value = 16'(iou_q - dist_q);
    r.overlap_seen = 1'b1;
    return r;
  endfunction

  // Acceptance on both sides, checking, watchdog
  always @(posedge clk_i) begin
    out_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni && push && !full) begin
      diou_expected = {diou_expected,
                       (typed_valid ? typed_word : score_pair(in_data_i))};
      moved = 1'b1;
    end
    if (rst_ni && pop && !empty) begin
      moved = 1'b1;
      if (diou_expected.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word diou=%0d overlap=%0b", $time,
                 out_data_o.diou_value, out_data_o.overlap_seen);
      end else begin
        want = diou_expected.pop_front();
        if (out_data_o.diou_value !== want.diou_value) begin
          n_errors++;
          $display("%0t: diou_value expected %0d actual %0d", $time,
                   want.diou_value, out_data_o.diou_value);
        end
        if (out_data_o.overlap_seen !== want.overlap_seen) begin
          n_errors++;
          $display("%0t: overlap_seen expected %0b actual %0b", $time,
                   want.overlap_seen, out_data_o.overlap_seen);
        end
      end
    end
    idle_cyc = moved ? 0 : idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: a randomly chosen stall pattern, plus one long hold
  int rx_cyc  = 0;
  int rx_mode = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= LONG_HOLD;
      hold_req  <= 1'b0;
    end
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 2);
    rx_cyc <= rx_cyc + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Offer one word and hold it until taken
  task automatic send_word(in_t p, bit typed, out_t want);
    typed_valid <= typed;
    typed_word  <= want;
    push      <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic gap(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic in_t random_pair();
    in_t p;
    p = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
    // Most pairs overlap: B sits near A with a comparable size
    if ($urandom_range(0, 9) < 8) begin
      p.a_width  = (SW)'($urandom_range(0, ($urandom_range(0, 1) ? 255 : 32767)));
      p.a_height = (SW)'($urandom_range(0, ($urandom_range(0, 1) ? 255 : 32767)));
      p.b_width  = (SW)'($urandom_range(0, 2 * p.a_width + 3));
      p.b_height = (SW)'($urandom_range(0, 2 * p.a_height + 3));
      p.b_center_x = p.a_center_x + (CW)'($signed($urandom_range(0, p.a_width)) -
                                          $signed(p.a_width / 2));
      p.b_center_y = p.a_center_y + (CW)'($signed($urandom_range(0, p.a_height)) -
                                          $signed(p.a_height / 2));
    end
    return p;
  endfunction

  function automatic in_t mk(int ax, int ay, int aw, int ah,
                             int bx, int by, int bw, int bh);
    in_t p;
    p.a_center_x = CW'(ax); p.a_center_y = CW'(ay);
    p.a_width = SW'(aw);    p.a_height = SW'(ah);
    p.b_center_x = CW'(bx); p.b_center_y = CW'(by);
    p.b_width = SW'(bw);    p.b_height = SW'(bh);
    return p;
  endfunction

  function automatic void add_row(in_t p, bit typed, int v, bit ov);
    row_t r;
    r.pair = p;
    r.typed = typed;
    r.want.diou_value = 16'(v);
    r.want.overlap_seen = ov;
    rows = {rows, r};
  endfunction

  // Stimulus
  initial begin
    out_t none;
    int   burst;
    none = '0;
    // Identical boxes: IoU is one, no center offset
    add_row(mk(0, 0, 40, 40, 0, 0, 40, 40), 1, 16384, 1);
    add_row(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767), 1, 16384, 1);
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1, 16384, 1);
    // Disjoint boxes in x, in y, and at opposite corners of the range
    add_row(mk(0, 0, 10, 10, 100, 0, 10, 10), 1, 0, 0);
    add_row(mk(0, 0, 10, 10, 0, -100, 10, 10), 1, 0, 0);
    add_row(mk(-32768, -32768, 0, 0, 32767, 32767, 0, 0), 1, 0, 0);
    add_row(mk(-32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767), 1, 0, 0);
    // Zero union: points at the same place, and a zero-height line on a point
    add_row(mk(5, 5, 0, 0, 5, 5, 0, 0), 1, 0, 0);
    add_row(mk(-32768, 32767, 0, 0, -32768, 32767, 0, 0), 1, 0, 0);
    add_row(mk(0, 0, 20, 0, 0, 0, 0, 0), 1, 0, 0);
    // Touching edges and corners, then wide boxes apart in x
    add_row(mk(0, 0, 10, 10, 10, 0, 10, 10), 0, 0, 0);
    add_row(mk(0, 0, 10, 10, 10, 10, 10, 10), 0, 0, 0);
    add_row(mk(-32768, 0, 32767, 8, 32767, 0, 32767, 8), 0, 0, 0);
    // Partial overlap, nesting, offset centers, widest extents
    add_row(mk(0, 0, 40, 40, 10, 10, 40, 40), 0, 0, 0);
    add_row(mk(0, 0, 400, 400, 3, -7, 10, 20), 0, 0, 0);
    add_row(mk(100, -100, 32767, 1, -100, 100, 1, 32767), 0, 0, 0);
    add_row(mk(-1, -1, 32767, 32767, 1, 1, 32767, 32767), 0, 0, 0);
    add_row(mk(32767, -32768, 32767, 32767, 16384, -16384, 32767, 32767), 0, 0, 0);
    add_row(mk(0, 0, 1, 1, 0, 0, 32767, 32767), 0, 0, 0);
    add_row(mk(0, 0, 2, 2, 1, 0, 2, 2), 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].pair, rows[i].typed, rows[i].want);
    gap(1);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        // Long receiver hold while words keep coming
        if (n == N_RANDOM / 3) hold_req = 1'b1;
        // Sender pause until everything has drained
        if (n == 2 * N_RANDOM / 3) begin
          push <= 1'b0;
          while (diou_expected.size() != 0) @(posedge clk_i);
        end
        send_word(random_pair(), 0, none);
      end
      if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
    end
    push <= 1'b0;
    typed_valid <= 1'b0;

    while (diou_expected.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
